[design/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg
// Shared sizes and types of the square matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MATRIX_SIZE   = 5;
  localparam int ELEMENT_WIDTH = 16;
  localparam int FIELD_WIDTH   = 16;
  localparam int PRODUCT_WIDTH = 35;
  localparam int CELL_COUNT    = MATRIX_SIZE * MATRIX_SIZE;
  localparam int MUL_W         = 2 * ELEMENT_WIDTH;
  localparam int K_W           = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int IDX_W         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W         = $clog2(2 * MATRIX_SIZE + 1);

  // operand travelling down the cell chain
  typedef struct packed {
    logic                     vld;
    logic [K_W-1:0]           k;
    logic [ELEMENT_WIDTH-1:0] a;
  } smm_flow_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic           b_we;
    logic [K_W-1:0] b_row;
    logic           shift;
  } smm_ctrl_t;

endpackage

[design/smm_in_if.sv]
// ----------------------------------------------------------------------------
// smm_in_if
// Input channel: one element of A and of B at the same position.
// ----------------------------------------------------------------------------
interface smm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_element;
  logic signed [15:0] b_element;

  modport source (output valid, output a_element, output b_element, input ready);
  modport sink   (input valid, input a_element, input b_element, output ready);
endinterface

[design/smm_out_if.sv]
// ----------------------------------------------------------------------------
// smm_out_if
// Output channel: one element of the product matrix, last flag on the final one.
// ----------------------------------------------------------------------------
interface smm_out_if;
  logic               valid;
  logic               ready;
  logic signed [34:0] product_element;
  logic               last_element;

  modport source (output valid, output product_element, output last_element, input ready);
  modport sink   (input valid, input product_element, input last_element, output ready);
endinterface

[design/smm_cell.sv]
// ----------------------------------------------------------------------------
// smm_cell
// One column cell: holds a column of B and an accumulator, multiplies the
// passing A element by B[k][col], and forwards the A element to its neighbor.
// ----------------------------------------------------------------------------
module smm_cell import smm_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  smm_flow_t                       flow_i,
  output smm_flow_t                       flow_o,
  input  smm_ctrl_t                       ctrl_i,
  input  logic [ELEMENT_WIDTH-1:0]        b_data_i,
  input  logic signed [PRODUCT_WIDTH-1:0] acc_i,
  output logic signed [PRODUCT_WIDTH-1:0] acc_o
);

  logic [ELEMENT_WIDTH-1:0]        b_col_q [MATRIX_SIZE];
  smm_flow_t                       flow_q;
  logic signed [MUL_W-1:0]         prod_q, prod_d;
  logic                            pvld_q;
  logic signed [PRODUCT_WIDTH-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_we) begin
      b_col_q[ctrl_i.b_row] <= b_data_i;
    end
  end

  assign prod_d = $signed(flow_i.a) * $signed(b_col_q[flow_i.k]);

  always_ff @(posedge clk_i) begin
    if (flow_i.vld) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q <= '0;
      pvld_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      flow_q <= flow_i;
      pvld_q <= flow_i.vld;
      // during readout the accumulators form a shift chain toward cell 0
      if (ctrl_i.shift) begin
        acc_q <= acc_i;
      end else if (pvld_q) begin
        acc_q <= acc_q + {{(PRODUCT_WIDTH-MUL_W){prod_q[MUL_W-1]}}, prod_q};
      end
    end
  end

  assign flow_o = flow_q;
  assign acc_o  = acc_q;

endmodule

[design/square_matrix_multiply_top.sv]
// ----------------------------------------------------------------------------
// square_matrix_multiply_top
// Loads A and B element by element, then computes C = A*B one row at a time
// on a chain of column cells and streams C out in row-major order.
// ----------------------------------------------------------------------------
// Loading: one input transfer per cycle while in_i.valid is high, N*N transfers
// per matrix pair. Per row of C: the row of A is fed into the chain, all sums
// settle, then N output transfers. A new matrix pair is only accepted once all
// of C has been streamed out, so pairs are not overlapped.
// Reset (rst_ni low, asynchronous) returns to loading at position zero.
// ----------------------------------------------------------------------------
module square_matrix_multiply_top import smm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  smm_in_if.sink      in_i,
  smm_out_if.source   out_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] ld_idx_q, ld_idx_d;
  logic [K_W-1:0]   ld_row_q, ld_row_d;
  logic [K_W-1:0]   ld_col_q, ld_col_d;
  logic [K_W-1:0]   row_q, row_d;
  logic [K_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;

  logic in_xfer, out_xfer, feed;
  logic last_row, last_col;

  logic [ELEMENT_WIDTH-1:0] a_mem [CELL_COUNT];
  logic [ELEMENT_WIDTH-1:0] a_rd_q;
  logic [K_W-1:0]           k_rd_q;
  logic                     feed_q;

  smm_flow_t                       flow   [MATRIX_SIZE+1];
  smm_ctrl_t                       ctrl   [MATRIX_SIZE];
  logic signed [PRODUCT_WIDTH-1:0] acc    [MATRIX_SIZE+1];

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == ST_EMIT);
  assign out_xfer    = out_o.valid && out_o.ready;

  assign feed     = (state_q == ST_CALC) && (cnt_q < CNT_W'(MATRIX_SIZE));
  assign last_row = (row_q == K_W'(MATRIX_SIZE - 1));
  assign last_col = (col_q == K_W'(MATRIX_SIZE - 1));

  always_comb begin
    state_d  = state_q;
    ld_idx_d = ld_idx_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    row_d    = row_q;
    col_d    = col_q;
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (ld_idx_q == IDX_W'(CELL_COUNT - 1)) begin
            state_d  = ST_CALC;
            ld_idx_d = '0;
            ld_row_d = '0;
            ld_col_d = '0;
            row_d    = '0;
            col_d    = '0;
            cnt_d    = '0;
            rd_idx_d = '0;
          end else begin
            ld_idx_d = ld_idx_q + 1'b1;
            if (ld_col_q == K_W'(MATRIX_SIZE - 1)) begin
              ld_col_d = '0;
              ld_row_d = ld_row_q + 1'b1;
            end else begin
              ld_col_d = ld_col_q + 1'b1;
            end
          end
        end
      end
      ST_CALC: begin
        if (feed) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        // last product reaches the last cell's accumulator at this count
        if (cnt_q == CNT_W'(2 * MATRIX_SIZE)) begin
          state_d = ST_EMIT;
          col_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (last_col) begin
            col_d = '0;
            if (last_row) begin
              state_d = ST_LOAD;
            end else begin
              row_d   = row_q + 1'b1;
              cnt_d   = '0;
              state_d = ST_CALC;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      ld_idx_q <= '0;
      ld_row_q <= '0;
      ld_col_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      feed_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ld_idx_q <= ld_idx_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      row_q    <= row_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      feed_q   <= feed;
    end
  end

  // A store, row-major; read in order during compute
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_mem[ld_idx_q] <= in_i.a_element[ELEMENT_WIDTH-1:0];
    end
    if (feed) begin
      a_rd_q <= a_mem[rd_idx_q];
      k_rd_q <= cnt_q[K_W-1:0];
    end
  end

  assign flow[0].vld = feed_q;
  assign flow[0].k   = k_rd_q;
  assign flow[0].a   = a_rd_q;
  assign acc[MATRIX_SIZE] = '0;

  for (genvar j = 0; j < MATRIX_SIZE; j++) begin : g_cell
    always_comb begin
      ctrl[j].b_we  = in_xfer && (ld_col_q == K_W'(j));
      ctrl[j].b_row = ld_row_q;
      ctrl[j].shift = out_xfer;
    end

    smm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .flow_i   (flow[j]),
      .flow_o   (flow[j+1]),
      .ctrl_i   (ctrl[j]),
      .b_data_i (in_i.b_element[ELEMENT_WIDTH-1:0]),
      .acc_i    (acc[j+1]),
      .acc_o    (acc[j])
    );
  end

  assign out_o.product_element = acc[0];
  assign out_o.last_element    = last_row && last_col;

endmodule
